// ----- rtl/vsfa_pkg.sv -----
`timescale 1ns / 1ps

package vsfa_pkg;

  localparam int ROW_PIXELS   = 80;
  localparam int FRAME_ROWS   = 60;
  localparam int HEADER_BYTES = 4;
  localparam int PACKET_LEN   = HEADER_BYTES + 2 * ROW_PIXELS;
  localparam int POS_W        = $clog2(PACKET_LEN);

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int ROW_W   = 6;
  localparam int EXP_W   = ROW_W + 1;
  localparam int COL_W   = 7;
  localparam int PIX_W   = 16;
  localparam int STAT_W  = 2;
  localparam int MISS_W  = 6;
  localparam int CNT_W   = 16;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 16;

  localparam int OUT_DATA_W = 56;
  localparam int OUT_USED_W = ROW_W + COL_W + PIX_W + STAT_W + MISS_W + CNT_W;

  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;
  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [MISS_W-1:0] MISS_MAX    = '1;

  localparam logic [CFG_W-1:0]  TIMEOUT_RST     = 16'd1000;
  localparam logic [CFG_W-1:0]  MAX_DISCARD_RST = 16'd1000;
  localparam logic [MISS_W-1:0] MAX_MISSING_RST = 6'd2;

  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TIMEOUT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SYNC_LOST = 2'd2;

  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DISCARD = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_MISSING = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SEQ
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_STORE,
    KIND_BADNIB
  } kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic              pixel_valid;
    logic [ROW_W-1:0]  pixel_row;
    logic [COL_W-1:0]  pixel_column;
    logic [PIX_W-1:0]  pixel_value;
    logic              frame_done;
    logic [STAT_W-1:0] frame_status;
    logic [MISS_W-1:0] missing_rows;
    logic [CNT_W-1:0]  resync_count;
  } result_t;

endpackage

// ----- rtl/video_spi_frame_assembler.sv -----
`timescale 1ns / 1ps

// Assembles one video frame from a byte stream of fixed-length packets (4 header
// bytes, then 80 big-endian 16-bit pixels) and reports one result per input
// transaction: a pixel write on the low byte of each pixel of a stored row, and
// a frame end with status ok, timeout or sync lost. A start command (tuser 2)
// arms a frame read, millisecond ticks (tuser 1) drive the timeout, stream bytes
// (tuser 0) carry the packets. The block takes one transaction per clock while
// out_tready holds no result back: each transaction passes an input register, the
// state update logic and a result register, with no stall of its own.
// Make configuration writes only while no transaction is in flight.

module video_spi_frame_assembler
  import vsfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // data_byte
  input  logic [CMD_W-1:0]      in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_row, pixel_column, pixel_value,
                                            // frame_status, missing_rows, resync_count
  output logic                  out_tuser,  // pixel_valid
  output logic                  out_tlast,  // frame_done
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  result_t  result;
  result_t  out_result;

  assign in_item.cmd       = in_tuser;
  assign in_item.data_byte = in_tdata;

  vsfa_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  vsfa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  vsfa_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tuser = out_result.pixel_valid;
  assign out_tlast = out_result.frame_done;
  assign out_tdata = {(OUT_DATA_W - OUT_USED_W)'(0),
                      out_result.resync_count,
                      out_result.missing_rows,
                      out_result.frame_status,
                      out_result.pixel_value,
                      out_result.pixel_column,
                      out_result.pixel_row};

endmodule

// ----- rtl/vsfa_in_reg.sv -----
`timescale 1ns / 1ps

module vsfa_in_reg
  import vsfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/vsfa_core.sv -----
`timescale 1ns / 1ps

module vsfa_core
  import vsfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              advance,
  input  in_item_t          item,
  output result_t           result
);

  logic [CFG_W-1:0]  timeout_r;
  logic [CFG_W-1:0]  max_discard_r;
  logic [MISS_W-1:0] max_missing_r;

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ROW_W-1:0]  header_row_r, header_row_nxt;
  kind_t             kind_r, kind_nxt;
  logic [EXP_W-1:0]  exp_row_r, exp_row_nxt;
  logic [MISS_W-1:0] missing_r, missing_nxt;
  logic [CNT_W-1:0]  discard_r, discard_nxt;
  logic [CNT_W-1:0]  elapsed_r, elapsed_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;
  logic [CNT_W-1:0]  resyncs_r, resyncs_nxt;

  logic [ROW_W-1:0]  row_in;
  logic [EXP_W-1:0]  row_ext;
  logic [EXP_W-1:0]  miss_sum;
  logic [POS_W-1:0]  pix_pos;
  logic              done;
  logic [STAT_W-1:0] status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      max_discard_r <= MAX_DISCARD_RST;
      max_missing_r <= MAX_MISSING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:     timeout_r     <= cfg_wdata;
        REG_MAX_DISCARD: max_discard_r <= cfg_wdata;
        REG_MAX_MISSING: max_missing_r <= cfg_wdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= '0;
      header_row_r <= '0;
      kind_r       <= KIND_SKIP;
      exp_row_r    <= EXP_W'(1);
      missing_r    <= '0;
      discard_r    <= '0;
      elapsed_r    <= '0;
      high_r       <= '0;
      resyncs_r    <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      header_row_r <= header_row_nxt;
      kind_r       <= kind_nxt;
      exp_row_r    <= exp_row_nxt;
      missing_r    <= missing_nxt;
      discard_r    <= discard_nxt;
      elapsed_r    <= elapsed_nxt;
      high_r       <= high_nxt;
      resyncs_r    <= resyncs_nxt;
    end
  end

  assign row_in  = item.data_byte[ROW_W-1:0];
  assign row_ext = {1'b0, row_in};
  assign pix_pos = pos_r - POS_W'(HEADER_BYTES);

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    header_row_nxt = header_row_r;
    kind_nxt       = kind_r;
    exp_row_nxt    = exp_row_r;
    missing_nxt    = missing_r;
    discard_nxt    = discard_r;
    elapsed_nxt    = elapsed_r;
    high_nxt       = high_r;
    resyncs_nxt    = resyncs_r;
    miss_sum       = '0;
    done           = 1'b0;
    status         = STAT_OK;
    result         = '0;

    case (item.cmd)
      CMD_START: begin
        phase_nxt   = PH_WAIT;
        pos_nxt     = '0;
        kind_nxt    = KIND_SKIP;
        exp_row_nxt = EXP_W'(1);
        missing_nxt = '0;
        discard_nxt = '0;
        elapsed_nxt = '0;
      end
      CMD_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (elapsed_r != CNT_MAX) begin
            elapsed_nxt = elapsed_r + CNT_W'(1);
          end
          if (elapsed_nxt > timeout_r) begin
            done   = 1'b1;
            status = STAT_TIMEOUT;
          end
        end
      end
      CMD_BYTE: begin
        if (phase_r != PH_IDLE) begin
          if (pos_r == POS_W'(0)) begin
            kind_nxt = ((item.data_byte & NIBBLE_MASK) == NIBBLE_MASK) ? KIND_BADNIB
                                                                       : KIND_SKIP;
          end else if (pos_r == POS_W'(1)) begin
            if (kind_r == KIND_BADNIB || row_ext >= EXP_W'(FRAME_ROWS)) begin
              kind_nxt = KIND_SKIP;
              if (discard_r != CNT_MAX) begin
                discard_nxt = discard_r + CNT_W'(1);
              end
              if (discard_nxt >= max_discard_r) begin
                done   = 1'b1;
                status = STAT_SYNC_LOST;
              end
            end else begin
              discard_nxt    = '0;
              header_row_nxt = row_in;
              kind_nxt       = KIND_SKIP;
              if (row_in == ROW_W'(0)) begin
                phase_nxt   = PH_SEQ;
                missing_nxt = '0;
                kind_nxt    = KIND_STORE;
              end else if (phase_r == PH_SEQ && row_ext >= exp_row_r) begin
                miss_sum    = {1'b0, missing_r} + (row_ext - exp_row_r);
                missing_nxt = (miss_sum > EXP_W'(MISS_MAX)) ? MISS_MAX
                                                            : miss_sum[MISS_W-1:0];
                kind_nxt    = KIND_STORE;
              end
            end
          end else if (pos_r >= POS_W'(HEADER_BYTES) && kind_r == KIND_STORE) begin
            if (!pix_pos[0]) begin
              high_nxt = item.data_byte;
            end else begin
              result.pixel_valid  = 1'b1;
              result.pixel_row    = header_row_r;
              result.pixel_column = COL_W'(pix_pos >> 1);
              result.pixel_value  = {high_r, item.data_byte};
            end
          end

          if (!done && pos_r == POS_W'(PACKET_LEN - 1)) begin
            pos_nxt = '0;
            if (kind_nxt == KIND_STORE) begin
              exp_row_nxt = {1'b0, header_row_nxt} + EXP_W'(1);
              if (exp_row_nxt >= EXP_W'(FRAME_ROWS)) begin
                done   = 1'b1;
                status = (missing_nxt > max_missing_r) ? STAT_SYNC_LOST : STAT_OK;
                result.missing_rows = missing_nxt;
              end
            end
            kind_nxt = KIND_SKIP;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      default: ;
    endcase

    if (done) begin
      phase_nxt = PH_IDLE;
      if (status != STAT_OK && resyncs_r != CNT_MAX) begin
        resyncs_nxt = resyncs_r + CNT_W'(1);
      end
    end

    result.frame_done   = done;
    result.frame_status = status;
    result.resync_count = resyncs_nxt;
  end

endmodule

// ----- rtl/vsfa_out_reg.sv -----
`timescale 1ns / 1ps

module vsfa_out_reg
  import vsfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  result_t result_r;

  assign advance    = item_valid && (!valid_r || out_ready);
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

endmodule

// ----- rtl/vsfa_checker.sv -----
`timescale 1ns / 1ps

module vsfa_checker
  import vsfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  localparam int STAT_LO = ROW_W + COL_W + PIX_W;
  localparam int MISS_LO = STAT_LO + STAT_W;

  logic [STAT_W-1:0] status;
  logic [MISS_W-1:0] missing;

  assign status  = out_tdata[STAT_LO +: STAT_W];
  assign missing = out_tdata[MISS_LO +: MISS_W];

  a_pixel_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[STAT_LO-1:0] == '0)
    else $error("pixel fields set without pixel write");

  a_frame_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> status == STAT_OK && missing == '0)
    else $error("frame fields set without frame end");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      (status == STAT_OK || status == STAT_TIMEOUT || status == STAT_SYNC_LOST))
    else $error("illegal frame status");

  a_timeout_no_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && status == STAT_TIMEOUT |-> missing == '0)
    else $error("missing rows reported on timeout");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind video_spi_frame_assembler vsfa_checker u_vsfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/video_spi_frame_assembler_tb.sv -----
`timescale 1ns / 1ps

module video_spi_frame_assembler_tb;
  import vsfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 240;
  localparam int NO_LIMIT      = 32'h7FFF_FFFF;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct packed {
    logic [OUT_DATA_W-OUT_USED_W-1:0] pad;
    logic [CNT_W-1:0]                 resync;
    logic [MISS_W-1:0]                missing;
    logic [STAT_W-1:0]                status;
    logic [PIX_W-1:0]                 value;
    logic [COL_W-1:0]                 column;
    logic [ROW_W-1:0]                 row;
  } out_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;   // data_byte
  logic [CMD_W-1:0]      in_tuser = CMD_BYTE;   // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // pixel_row, pixel_column, pixel_value,
                                     // frame_status, missing_rows, resync_count
  logic                  out_tuser;  // pixel_valid
  logic                  out_tlast;  // frame_done
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = REG_TIMEOUT;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  video_spi_frame_assembler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // frame assembly state
  phase_t            ph = PH_IDLE;
  logic [8:0]        pos = '0;
  logic [ROW_W-1:0]  hdr_row = '0;
  kind_t             kind = KIND_SKIP;
  logic [EXP_W-1:0]  exp_row = EXP_W'(1);
  logic [MISS_W-1:0] miss = '0;
  logic [CNT_W-1:0]  disc_run = '0;
  logic [CNT_W-1:0]  elapsed = '0;
  logic [BYTE_W-1:0] held = '0;
  logic [CNT_W-1:0]  resync = '0;
  logic [CFG_W-1:0]  timeout_lim = TIMEOUT_RST;
  logic [CFG_W-1:0]  discard_lim = MAX_DISCARD_RST;
  logic [MISS_W-1:0] missing_lim = MAX_MISSING_RST;

  result_t step_out;
  result_t frame_events_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int tick_pct = 0;
  int stop_items = NO_LIMIT;
  logic holding = 1'b0;
  event hold_kick;

  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int live_items = 0;
  int pixels_written = 0;
  int ok_frames = 0;
  int timeout_frames = 0;
  int lost_frames = 0;
  int frames_ended = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void close_frame(input logic [STAT_W-1:0] status,
                                      input logic [MISS_W-1:0] missing);
    step_out.frame_done   = 1'b1;
    step_out.frame_status = status;
    step_out.missing_rows = missing;
    ph = PH_IDLE;
    if (status != STAT_OK && resync != CNT_MAX) resync++;
    frames_ended++;
    case (status)
      STAT_OK:      ok_frames++;
      STAT_TIMEOUT: timeout_frames++;
      default:      lost_frames++;
    endcase
  endfunction

  task automatic track_stream_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
    int p;
    int m;
    step_out = '0;
    if (cmd == CMD_START) begin
      live_items++;
      ph       = PH_WAIT;
      pos      = '0;
      kind     = KIND_SKIP;
      exp_row  = EXP_W'(1);
      miss     = '0;
      disc_run = '0;
      elapsed  = '0;
    end else if (cmd == CMD_TICK && ph != PH_IDLE) begin
      live_items++;
      if (elapsed != CNT_MAX) elapsed++;
      if (elapsed > timeout_lim) close_frame(STAT_TIMEOUT, '0);
    end else if (cmd == CMD_BYTE && ph != PH_IDLE) begin
      live_items++;
      if (pos == 0) begin
        kind = ((b & NIBBLE_MASK) == NIBBLE_MASK) ? KIND_BADNIB : KIND_SKIP;
      end else if (pos == 1) begin
        if (kind == KIND_BADNIB || b[ROW_W-1:0] >= FRAME_ROWS) begin
          kind = KIND_SKIP;
          if (disc_run != CNT_MAX) disc_run++;
          if (disc_run >= discard_lim) close_frame(STAT_SYNC_LOST, '0);
        end else begin
          disc_run = '0;
          hdr_row  = b[ROW_W-1:0];
          kind     = KIND_SKIP;
          if (b[ROW_W-1:0] == 0) begin
            ph   = PH_SEQ;
            miss = '0;
            kind = KIND_STORE;
          end else if (ph == PH_SEQ && b[ROW_W-1:0] >= exp_row) begin
            m    = miss + b[ROW_W-1:0] - exp_row;
            miss = (m > MISS_MAX) ? MISS_MAX : MISS_W'(m);
            kind = KIND_STORE;
          end
        end
      end else if (pos >= HEADER_BYTES && kind == KIND_STORE) begin
        p = pos - HEADER_BYTES;
        if (p % 2 == 0) begin
          held = b;
        end else begin
          step_out.pixel_valid  = 1'b1;
          step_out.pixel_row    = hdr_row;
          step_out.pixel_column = COL_W'(p >> 1);
          step_out.pixel_value  = {held, b};
          pixels_written++;
        end
      end
      if (ph != PH_IDLE && pos + 1 >= PACKET_LEN) begin
        pos = '0;
        if (kind == KIND_STORE) begin
          exp_row = {1'b0, hdr_row} + EXP_W'(1);
          if (exp_row >= FRAME_ROWS)
            close_frame((miss > missing_lim) ? STAT_SYNC_LOST : STAT_OK, miss);
        end
        kind = KIND_SKIP;
      end else begin
        pos = pos + 9'd1;
      end
    end
    step_out.resync_count = resync;
    frame_events_q.push_back(step_out);
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    track_stream_item(cmd, b);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (frame_events_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TIMEOUT:     timeout_lim = val;
      REG_MAX_DISCARD: discard_lim = val;
      REG_MAX_MISSING: missing_lim = val[MISS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [BYTE_W-1:0] good_hdr();
    logic [BYTE_W-1:0] h;
    h = BYTE_W'($urandom());
    if (h[3:0] == NIBBLE_MASK[3:0]) h[3:0] = 4'($urandom_range(14));
    return h;
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg_value(input logic [IDX_W-1:0] idx);
    case (idx)
      REG_TIMEOUT:
        case ($urandom_range(3))
          0:       return '0;
          1:       return CNT_MAX;
          2:       return CFG_W'($urandom_range(5, 60));
          default: return CFG_W'($urandom());
        endcase
      REG_MAX_DISCARD:
        case ($urandom_range(3))
          0:       return '0;
          1:       return CFG_W'(1);
          2:       return CNT_MAX;
          default: return CFG_W'($urandom_range(2, 4));
        endcase
      default:
        case ($urandom_range(2))
          0:       return '0;
          1:       return CFG_W'(MISS_MAX);
          default: return CFG_W'($urandom_range(MISS_MAX));
        endcase
    endcase
  endfunction

  // Send len bytes of one packet; ticks and unknown commands interleave at random.
  task automatic send_packet(input logic [BYTE_W-1:0] h0, input logic [ROW_W-1:0] row,
                             input int len);
    logic [BYTE_W-1:0] rb;
    logic [BYTE_W-1:0] x;
    rb = BYTE_W'($urandom());
    rb[ROW_W-1:0] = row;
    for (int i = 0; i < len && items_sent < stop_items; i++) begin
      if (tick_pct != 0 && $urandom_range(99) < tick_pct)
        send_item(CMD_TICK, BYTE_W'($urandom()));
      if ($urandom_range(199) == 0) send_item(CMD_NOP, BYTE_W'($urandom()));
      x = (i == 0) ? h0 : (i == 1) ? rb : BYTE_W'($urandom());
      send_item(CMD_BYTE, x);
    end
  endtask

  task automatic run_frame_segment();
    logic [BYTE_W-1:0] h;
    int r;
    int cur;
    int nxt;
    case ($urandom_range(3))
      0:       tick_pct = 0;
      1:       tick_pct = 1;
      2:       tick_pct = 2;
      default: tick_pct = 8;
    endcase
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 4)) send_item(CMD_BYTE, BYTE_W'($urandom()));
    send_item(CMD_START, BYTE_W'($urandom()));
    cur = -1;
    if ($urandom_range(4) == 0)
      send_packet(good_hdr(), ROW_W'($urandom_range(1, FRAME_ROWS - 1)), PACKET_LEN);
    while (ph != PH_IDLE && items_sent < stop_items) begin
      r = $urandom_range(99);
      if (cur < 0) begin
        send_packet(good_hdr(), '0, PACKET_LEN);
        cur = 0;
      end else if (r < 7) begin
        if ($urandom_range(1)) begin
          h = BYTE_W'($urandom());
          h[3:0] = NIBBLE_MASK[3:0];
          send_packet(h, ROW_W'($urandom_range(MISS_MAX)), PACKET_LEN);
        end else begin
          send_packet(good_hdr(), ROW_W'($urandom_range(FRAME_ROWS, MISS_MAX)), PACKET_LEN);
        end
      end else if (r < 12) begin
        if (cur > 0) send_packet(good_hdr(), ROW_W'($urandom_range(1, cur)), PACKET_LEN);
      end else if (r < 16) begin
        send_packet(good_hdr(), ROW_W'(cur + 1), $urandom_range(1, PACKET_LEN - 1));
        if (ph != PH_IDLE) begin
          send_item(CMD_START, BYTE_W'($urandom()));
          cur = -1;
        end
      end else if (r < 19) begin
        send_packet(good_hdr(), '0, PACKET_LEN);
        cur = 0;
      end else begin
        if ($urandom_range(2) == 0) nxt = FRAME_ROWS - 1;
        else nxt = cur + 1 + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
        if (nxt > FRAME_ROWS - 1) nxt = FRAME_ROWS - 1;
        send_packet(good_hdr(), ROW_W'(nxt), PACKET_LEN);
        cur = nxt;
      end
    end
  endtask

  task automatic test_idle_commands();
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_NOP, 8'hA5);
  endtask

  task automatic test_start_while_active();
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hC0);
    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_BYTE, 8'hAA);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_START, 8'h5A);
  endtask

  task automatic test_zero_discard_limit();
    settle();
    write_reg(REG_MAX_DISCARD, '0);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_BYTE, 8'h0F);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h12);
  endtask

  task automatic test_timeout_zero();
    settle();
    write_reg(REG_TIMEOUT, '0);
    send_item(CMD_START, 8'h33);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'hC3);
  endtask

  task automatic test_row_out_of_range();
    settle();
    write_reg(REG_MAX_DISCARD, CFG_W'(1));
    write_reg(REG_TIMEOUT, TIMEOUT_RST);
    send_item(CMD_START, 8'h81);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h3C);
  endtask

  task automatic test_output_backpressure();
    settle();
    write_reg(REG_MAX_DISCARD, CNT_MAX);
    write_reg(REG_MAX_MISSING, CFG_W'(MISS_MAX));
    idle_pct  = 0;
    stall_pct = 0;
    tick_pct  = 0;
    send_item(CMD_START, BYTE_W'($urandom()));
    -> hold_kick;
    send_packet(good_hdr(), '0, PACKET_LEN);
    send_packet(good_hdr(), ROW_W'(FRAME_ROWS - 1), PACKET_LEN);
  endtask

  task automatic test_random_frames(input int idle_in, input int stall_in,
                                    input logic [CFG_W-1:0] t_lim,
                                    input logic [CFG_W-1:0] d_lim,
                                    input logic [CFG_W-1:0] m_lim);
    logic [IDX_W-1:0] idx;
    settle();
    idle_pct  = idle_in;
    stall_pct = stall_in;
    write_reg(REG_TIMEOUT, t_lim);
    write_reg(REG_MAX_DISCARD, d_lim);
    write_reg(REG_MAX_MISSING, m_lim);
    stop_items = items_sent + RANDOM_ITEMS / 4;
    while (items_sent < stop_items) begin
      if ($urandom_range(3) == 0) begin
        settle();
        idx = IDX_W'($urandom_range(2));
        write_reg(idx, pick_reg_value(idx));
      end
      run_frame_segment();
    end
    stop_items = NO_LIMIT;
  endtask

  initial begin
    forever begin
      @(hold_kick);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  always @(posedge clk) begin
    out_tready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_word_t ow;
    result_t   want;
    if (rst_n && out_tvalid && out_tready) begin
      ow = out_tdata;
      if (frame_events_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual %h/%b/%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = frame_events_q.pop_front();
        check_field("pixel_valid", int'(want.pixel_valid), int'(out_tuser));
        check_field("pixel_row", int'(want.pixel_row), int'(ow.row));
        check_field("pixel_column", int'(want.pixel_column), int'(ow.column));
        check_field("pixel_value", int'(want.pixel_value), int'(ow.value));
        check_field("frame_done", int'(want.frame_done), int'(out_tlast));
        check_field("frame_status", int'(want.frame_status), int'(ow.status));
        check_field("missing_rows", int'(want.missing_rows), int'(ow.missing));
        check_field("resync_count", int'(want.resync_count), int'(ow.resync));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             frame_events_q.size());
    $display("** video_spi_frame_assembler: FAILED **");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_commands();
    test_start_while_active();
    test_zero_discard_limit();
    test_timeout_zero();
    test_row_out_of_range();
    test_output_backpressure();
    test_random_frames(0, 0, CFG_W'(30), CFG_W'(2), CFG_W'(MISS_MAX));
    test_random_frames(50, 0, CNT_MAX, CNT_MAX, '0);
    test_random_frames(0, 50, CFG_W'(12), CFG_W'(1), CFG_W'(MAX_MISSING_RST));
    test_random_frames(35, 35, pick_reg_value(REG_TIMEOUT), pick_reg_value(REG_MAX_DISCARD),
                       pick_reg_value(REG_MAX_MISSING));
    settle();
    $display("run covered %0d transactions (%0d acted on), %0d pixel writes", items_sent,
             live_items, pixels_written);
    $display("frames ended: %0d ok, %0d timed out, %0d sync lost; %0d mismatches", ok_frames,
             timeout_frames, lost_frames, mismatches);
    if (mismatches == 0) begin
      $display("** video_spi_frame_assembler: PASSED **");
    end else begin
      $display("** video_spi_frame_assembler: FAILED **");
    end
    $finish;
  end

endmodule
